FILE: design/kmp_pkg.sv
`timescale 1ns / 1ps

package kmp_pkg;

    // Pattern store depth and occurrence counter width
    localparam int MAX_PATTERN = 64;
    localparam int COUNT_WIDTH = 32;

    // Derived widths: a length runs 0..MAX_PATTERN, an index 0..MAX_PATTERN-1
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Fixed widths of the result fields
    localparam int OUT_COUNT_W = 32;
    localparam int OUT_LEN_W   = 7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Action codes on the input channel
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TEXT   = 2'd2;

    // Classified operation handed to the back end
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_TEXT,
        OP_NOP
    } t_op;

    // Error codes on the result channel
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       last;
    } t_cmd;

endpackage

FILE: design/kmp_in_if.sv
`timescale 1ns / 1ps

interface kmp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       text_end;

    modport source (output valid, output action, output data_byte, output text_end,
                    input ready);
    modport sink   (input valid, input action, input data_byte, input text_end,
                    output ready);
endinterface

FILE: design/kmp_out_if.sv
`timescale 1ns / 1ps

interface kmp_out_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [31:0] match_count;
    logic [6:0]  matched_length;
    logic [1:0]  error;

    modport source (output valid, output match_found, output match_count,
                    output matched_length, output error, input ready);
    modport sink   (input valid, input match_found, input match_count,
                    input matched_length, input error, output ready);
endinterface

FILE: design/kmp_front.sv
`timescale 1ns / 1ps

module kmp_front (
    kmp_in_if.sink          i_in,
    output kmp_pkg::t_cmd   o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready
);

    kmp_pkg::t_op op;

    // Classify the action; the unused code becomes a no-op
    always_comb begin
        unique case (i_in.action)
            kmp_pkg::ACT_CLEAR:  op = kmp_pkg::OP_CLEAR;
            kmp_pkg::ACT_APPEND: op = kmp_pkg::OP_APPEND;
            kmp_pkg::ACT_TEXT:   op = kmp_pkg::OP_TEXT;
            default:             op = kmp_pkg::OP_NOP;
        endcase
    end

    // Keep the end marker only on text beats
    assign o_cmd.op        = op;
    assign o_cmd.data_byte = i_in.data_byte;
    assign o_cmd.last      = i_in.text_end & (op == kmp_pkg::OP_TEXT);

    assign o_cmd_valid = i_in.valid;
    assign i_in.ready  = i_cmd_ready;

endmodule

FILE: design/kmp_queue.sv
`timescale 1ns / 1ps

module kmp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kmp_pkg::t_cmd   i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    output kmp_pkg::t_cmd   o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready
);

    kmp_pkg::t_cmd                 r_slot [kmp_pkg::QUEUE_DEPTH];
    logic [kmp_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [kmp_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [kmp_pkg::QFILL_W-1:0]   r_fill;
    logic                          push;
    logic                          pop;

    assign o_cmd_ready = (r_fill != kmp_pkg::QFILL_W'(kmp_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_cmd_valid & o_cmd_ready;
    assign pop         = o_cmd_valid & i_cmd_ready;

    // Store incoming beats
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

FILE: design/kmp_engine.sv
`timescale 1ns / 1ps

module kmp_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kmp_pkg::t_cmd   i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    kmp_out_if.source       o_out
);

    localparam int LEN_W = kmp_pkg::LEN_W;
    localparam int IDX_W = kmp_pkg::IDX_W;
    localparam int CNT_W = kmp_pkg::COUNT_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FALL,
        S_CMP
    } t_state;

    // Pattern and border memories
    logic [7:0]       pattern_mem [kmp_pkg::MAX_PATTERN];
    logic [LEN_W-1:0] border_mem  [kmp_pkg::MAX_PATTERN];
    logic [7:0]       pat_rdata;
    logic [LEN_W-1:0] bor_rdata;

    // Control and working registers
    t_state           r_state,  n_state;
    kmp_pkg::t_cmd    r_cmd,    n_cmd;
    logic [LEN_W-1:0] r_plen,   n_plen;
    logic [LEN_W-1:0] r_bbl,    n_bbl;
    logic [LEN_W-1:0] r_mlen,   n_mlen;
    logic [LEN_W-1:0] r_k,      n_k;
    logic [CNT_W-1:0] r_count,  n_count;

    // Output register
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [kmp_pkg::OUT_COUNT_W-1:0] r_out_count;
    logic [kmp_pkg::OUT_LEN_W-1:0]   r_out_len;
    kmp_pkg::t_err                r_out_err;

    // Result produced this cycle
    logic             emit;
    logic             e_found;
    logic [CNT_W-1:0] e_count;
    logic [LEN_W-1:0] e_len;
    kmp_pkg::t_err    e_err;

    // Memory access
    logic [LEN_W-1:0] rd_k;
    logic [LEN_W-1:0] rd_km1;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       pat_wdata;
    logic [LEN_W-1:0] bor_wdata;

    logic             slot_free;
    logic             hit;
    logic [LEN_W-1:0] k_next;
    logic             full_match;
    logic [CNT_W-1:0] count_inc;

    assign slot_free = !r_out_valid || o_out.ready;
    assign rd_km1    = rd_k - LEN_W'(1);
    assign hit       = (pat_rdata == r_cmd.data_byte);
    assign k_next    = hit ? (r_k + LEN_W'(1)) : '0;
    assign full_match = (k_next == r_plen);
    assign count_inc = (full_match && (r_count != {CNT_W{1'b1}})) ?
                       (r_count + CNT_W'(1)) : r_count;

    // Read at prefix length k: pattern byte k and border entry k-1
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            pattern_mem[mem_waddr] <= pat_wdata;
            border_mem[mem_waddr]  <= bor_wdata;
        end
        pat_rdata <= pattern_mem[rd_k[IDX_W-1:0]];
        bor_rdata <= border_mem[rd_km1[IDX_W-1:0]];
    end

    // Sequence commands and walk the border chain
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_plen      = r_plen;
        n_bbl       = r_bbl;
        n_mlen      = r_mlen;
        n_k         = r_k;
        n_count     = r_count;
        o_cmd_ready = 1'b0;
        rd_k        = r_k;
        mem_we      = 1'b0;
        mem_waddr   = r_plen[IDX_W-1:0];
        pat_wdata   = r_cmd.data_byte;
        bor_wdata   = k_next;
        emit        = 1'b0;
        e_found     = 1'b0;
        e_count     = r_count;
        e_len       = r_mlen;
        e_err       = kmp_pkg::ERR_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_cmd_ready = 1'b1;
                    n_cmd       = i_cmd;
                    unique case (i_cmd.op)
                        kmp_pkg::OP_CLEAR: begin
                            n_plen  = '0;
                            n_bbl   = '0;
                            n_mlen  = '0;
                            n_count = '0;
                            emit    = 1'b1;
                            e_count = '0;
                            e_len   = '0;
                        end
                        kmp_pkg::OP_APPEND: begin
                            if (r_plen >= LEN_W'(kmp_pkg::MAX_PATTERN)) begin
                                emit  = 1'b1;
                                e_err = kmp_pkg::ERR_FULL;
                            end else if (r_plen == '0) begin
                                // First byte: its border is empty
                                n_cmd     = i_cmd;
                                mem_we    = 1'b1;
                                pat_wdata = i_cmd.data_byte;
                                bor_wdata = '0;
                                n_bbl     = '0;
                                n_plen    = LEN_W'(1);
                                emit      = 1'b1;
                            end else begin
                                n_k     = r_bbl;
                                rd_k    = r_bbl;
                                n_state = S_CMP;
                            end
                        end
                        kmp_pkg::OP_TEXT: begin
                            if (r_plen == '0) begin
                                n_mlen  = '0;
                                emit    = 1'b1;
                                e_len   = '0;
                                e_err   = kmp_pkg::ERR_EMPTY;
                                if (i_cmd.last) begin
                                    n_count = '0;
                                end
                            end else if (r_mlen >= r_plen) begin
                                // Full match last time: fetch border of whole pattern
                                rd_k    = r_plen;
                                n_state = S_FALL;
                            end else begin
                                n_k     = r_mlen;
                                rd_k    = r_mlen;
                                n_state = S_CMP;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_FALL: begin
                n_k     = bor_rdata;
                rd_k    = bor_rdata;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit || (r_k == '0)) begin
                    if (slot_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                        if (r_cmd.op == kmp_pkg::OP_APPEND) begin
                            mem_we = 1'b1;
                            n_bbl  = k_next;
                            n_plen = r_plen + LEN_W'(1);
                        end else begin
                            e_found = full_match;
                            e_count = count_inc;
                            e_len   = k_next;
                            n_mlen  = r_cmd.last ? '0 : k_next;
                            n_count = r_cmd.last ? '0 : count_inc;
                        end
                    end
                end else begin
                    // Drop back along the border chain
                    n_k  = bor_rdata;
                    rd_k = bor_rdata;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plen      <= '0;
            r_bbl       <= '0;
            r_mlen      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_plen  <= n_plen;
            r_bbl   <= n_bbl;
            r_mlen  <= n_mlen;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cmd <= n_cmd;
        r_k   <= n_k;
        if (emit) begin
            r_out_found <= e_found;
            r_out_count <= kmp_pkg::OUT_COUNT_W'(e_count);
            r_out_len   <= kmp_pkg::OUT_LEN_W'(e_len);
            r_out_err   <= e_err;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.match_found    = r_out_found;
    assign o_out.match_count    = r_out_count;
    assign o_out.matched_length = r_out_len;
    assign o_out.error          = r_out_err;

endmodule

FILE: design/kmp_substring_count.sv
`timescale 1ns / 1ps

// Knuth-Morris-Pratt substring counter. Each input beat yields exactly one result
// beat. Beats enter a two-deep command queue and are executed one at a time by an
// engine that keeps the pattern bytes and border lengths in a 64-entry memory with
// one registered read port. Clear, no-op, error cases and the first pattern byte
// are finished in the idle state; an appended pattern byte or a text byte goes to
// the compare state and steps back along the border chain on each mismatch, and a
// text byte after a full match first passes the fall state to fetch the border of
// the whole pattern. A result waits in the output register; the engine takes no
// new beat until that register is free.
module kmp_substring_count (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kmp_in_if.sink     i_in,
    kmp_out_if.source  o_out
);

    kmp_pkg::t_cmd front_cmd;
    logic          front_valid;
    logic          front_ready;
    kmp_pkg::t_cmd queue_cmd;
    logic          queue_valid;
    logic          queue_ready;

    kmp_front u_front (
        .i_in        (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    kmp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (front_cmd),
        .i_cmd_valid (front_valid),
        .o_cmd_ready (front_ready),
        .o_cmd       (queue_cmd),
        .o_cmd_valid (queue_valid),
        .i_cmd_ready (queue_ready)
    );

    kmp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // A completed occurrence always reports a non-empty match and no error
    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.match_found) |->
        (o_out.matched_length != '0 && o_out.error == kmp_pkg::ERR_NONE))
        else $error("match reported with empty length or error");

    // A text beat against an empty pattern matches nothing
    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error == kmp_pkg::ERR_EMPTY) |->
        (!o_out.match_found && o_out.matched_length == '0))
        else $error("empty-pattern error with match state");

    // A beat taken into an empty queue is offered to the engine next cycle
    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && front_ready && !queue_valid) |=> queue_valid)
        else $error("accepted beat lost in command queue");
`endif

endmodule
